// ===== rtl/peer_reorg_penalty_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// peer_reorg_penalty_tracker_assert.svh
// assertion macros for the tracker rtl
// ----------------------------------------------------------------------------
`ifndef PEER_REORG_PENALTY_TRACKER_ASSERT_SVH
`define PEER_REORG_PENALTY_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PRPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prpt check failed");

// next-cycle implication, checked outside reset
`define PRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prpt check failed");

`endif

// ===== rtl/prpt_pkg.sv =====
// ----------------------------------------------------------------------------
// prpt_pkg
// types, codes and helpers for the peer reorg penalty tracker
// ----------------------------------------------------------------------------
package prpt_pkg;

    // item modes
    typedef enum logic [1:0] {
        MODE_TRACK  = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_PUNISH = 2'd2,
        MODE_RESET  = 2'd3
    } t_mode;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } t_state;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_THRESHOLD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SCORE     = 8'd3;

    // register reset values
    localparam logic [31:0] WINDOW_TICKS_RST   = 32'd3600;
    localparam logic [15:0] DEEP_THRESHOLD_RST = 16'd6;
    localparam logic [7:0]  MAX_ATTEMPTS_RST   = 8'd10;
    localparam logic [9:0]  BASE_SCORE_RST     = 10'd10;

    // score limits
    localparam logic [15:0] SCORE_FLOOR = 16'd150;
    localparam logic [15:0] SCORE_MAX   = 16'hffff;
    localparam logic [7:0]  COUNT_MAX   = 8'hff;

    // input beat
    typedef struct packed {
        t_mode       mode;
        logic [5:0]  peer_index;
        logic [15:0] depth;
        logic [31:0] now;
    } t_in;

    // output beat
    typedef struct packed {
        logic        should_punish;
        logic [15:0] score;
    } t_out;

    // configuration registers
    typedef struct packed {
        logic [31:0] window_ticks;
        logic [15:0] deep_threshold;
        logic [7:0]  max_attempts;
        logic [9:0]  base_score;
    } t_cfg;

    // one peer table entry
    typedef struct packed {
        logic [31:0] last_time;
        logic [7:0]  attempt_count;
        logic [7:0]  deep_count;
        logic        penalty_flag;
    } t_entry;

    // saturating 8-bit increment
    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        sat_inc8 = (v == COUNT_MAX) ? v : v + 8'd1;
    endfunction

endpackage

// ===== rtl/prpt_table.sv =====
// ----------------------------------------------------------------------------
// prpt_table
// single-port-write, registered-read peer table memory
// ----------------------------------------------------------------------------
module prpt_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output prpt_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  prpt_pkg::t_entry  i_wr_data
);

    prpt_pkg::t_entry r_mem [DEPTH];
    prpt_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/prpt_update.sv =====
// ----------------------------------------------------------------------------
// prpt_update
// modify step: new entry contents and result beat for one item
// ----------------------------------------------------------------------------
module prpt_update (
    input  prpt_pkg::t_in     i_item,
    input  logic              i_in_range,
    input  prpt_pkg::t_entry  i_entry,
    input  prpt_pkg::t_cfg    i_cfg,
    output logic              o_wr_en,
    output prpt_pkg::t_entry  o_entry,
    output prpt_pkg::t_out    o_result
);

    logic [32:0] w_elapsed;
    logic        w_stale;
    logic [7:0]  w_att_base;
    logic [7:0]  w_deep_base;
    logic        w_over_limit;
    logic [18:0] w_prod;
    logic [19:0] w_dbl;
    logic [15:0] w_sat;

    // idle span, negative when time went backwards
    assign w_elapsed    = {1'b0, i_item.now} - {1'b0, i_entry.last_time};
    assign w_stale      = !w_elapsed[32] && (w_elapsed[31:0] > i_cfg.window_ticks);
    assign w_att_base   = w_stale ? 8'd0 : i_entry.attempt_count;
    assign w_deep_base  = w_stale ? 8'd0 : i_entry.deep_count;
    assign w_over_limit = i_entry.attempt_count > i_cfg.max_attempts;

    // score: base * (1 + deep), doubled past the limit, clamped
    assign w_prod = i_cfg.base_score * ({1'b0, i_entry.deep_count} + 9'd1);
    assign w_dbl  = w_over_limit ? {w_prod, 1'b0} : {1'b0, w_prod};
    assign w_sat  = (w_dbl[19:16] != 4'd0) ? prpt_pkg::SCORE_MAX : w_dbl[15:0];

    always_comb begin
        o_wr_en  = 1'b0;
        o_entry  = i_entry;
        o_result = '0;
        if (i_in_range) begin
            unique case (i_item.mode)
                prpt_pkg::MODE_TRACK: begin
                    o_wr_en                = 1'b1;
                    o_entry.last_time      = i_item.now;
                    o_entry.attempt_count  = prpt_pkg::sat_inc8(w_att_base);
                    o_entry.deep_count     = (i_item.depth > i_cfg.deep_threshold)
                                           ? prpt_pkg::sat_inc8(w_deep_base)
                                           : w_deep_base;
                end
                prpt_pkg::MODE_QUERY: begin
                    o_result.should_punish = w_over_limit || (i_entry.deep_count > 8'd1)
                                           || i_entry.penalty_flag;
                end
                prpt_pkg::MODE_PUNISH: begin
                    o_wr_en              = 1'b1;
                    o_entry.penalty_flag = 1'b1;
                    o_result.score       = (w_sat < prpt_pkg::SCORE_FLOOR)
                                         ? prpt_pkg::SCORE_FLOOR : w_sat;
                end
                prpt_pkg::MODE_RESET: begin
                    o_wr_en = 1'b1;
                    o_entry = '0;
                end
                default: begin
                    o_wr_en = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/peer_reorg_penalty_tracker.sv =====
// ----------------------------------------------------------------------------
// peer_reorg_penalty_tracker
// per-peer reorg attempt table with punish query and penalty scoring
// ----------------------------------------------------------------------------
// The table sits in one synchronous memory with a registered read. For each
// item the accept edge issues the table read and the edge that leaves
// ST_BUSY applies the update, writes the entry back and loads the result
// register, and no new item is taken before then. Because the next read is
// issued only after the write-back edge, items on the same peer never see a
// stale entry. A new item is taken while a result still waits in the output
// register; the update stalls only if that register is still full. After
// reset a clearing pass zeroes all PEER_SLOTS entries (64 by default), one
// entry per cycle, with o_in_ready low; configuration writes are taken at
// any time and should be made while the block is idle.
// Items whose peer_index is not below PEER_SLOTS leave the table alone and
// return zero fields.
// ----------------------------------------------------------------------------
`include "peer_reorg_penalty_tracker_assert.svh"

module peer_reorg_penalty_tracker #(
    parameter int PEER_SLOTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  prpt_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output prpt_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prpt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    localparam int AW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

    prpt_pkg::t_state r_state;
    prpt_pkg::t_state n_state;
    logic             w_accept;
    logic             w_done;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    n_clr_addr;
    prpt_pkg::t_in    r_item;
    logic             r_in_range;
    prpt_pkg::t_cfg   r_cfg;
    logic             r_out_valid;
    prpt_pkg::t_out   r_out;
    prpt_pkg::t_entry w_rd_entry;
    prpt_pkg::t_entry w_upd_entry;
    prpt_pkg::t_out   w_result;
    logic             w_upd_wr;
    logic             w_mem_wr;
    logic [AW-1:0]    w_mem_wr_addr;
    prpt_pkg::t_entry w_mem_wr_data;

    // controller state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prpt_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // next state, handshake and write-port steering
    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        o_in_ready    = 1'b0;
        w_done        = 1'b0;
        w_mem_wr      = 1'b0;
        w_mem_wr_addr = AW'(r_item.peer_index);
        w_mem_wr_data = w_upd_entry;
        unique case (r_state)
            prpt_pkg::ST_CLEAR: begin
                w_mem_wr      = 1'b1;
                w_mem_wr_addr = r_clr_addr;
                w_mem_wr_data = '0;
                n_clr_addr    = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(PEER_SLOTS - 1)) begin
                    n_state = prpt_pkg::ST_IDLE;
                end
            end
            prpt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = prpt_pkg::ST_BUSY;
                end
            end
            prpt_pkg::ST_BUSY: begin
                w_done   = !r_out_valid || i_out_ready;
                w_mem_wr = w_done && w_upd_wr;
                if (w_done) begin
                    n_state = prpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prpt_pkg::ST_CLEAR;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // item capture at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item     <= i_in;
            r_in_range <= (32'(i_in.peer_index) < 32'(PEER_SLOTS));
        end
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks   <= prpt_pkg::WINDOW_TICKS_RST;
            r_cfg.deep_threshold <= prpt_pkg::DEEP_THRESHOLD_RST;
            r_cfg.max_attempts   <= prpt_pkg::MAX_ATTEMPTS_RST;
            r_cfg.base_score     <= prpt_pkg::BASE_SCORE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prpt_pkg::CFG_WINDOW_TICKS:   r_cfg.window_ticks   <= i_cfg_data;
                prpt_pkg::CFG_DEEP_THRESHOLD: r_cfg.deep_threshold <= i_cfg_data[15:0];
                prpt_pkg::CFG_MAX_ATTEMPTS:   r_cfg.max_attempts   <= i_cfg_data[7:0];
                prpt_pkg::CFG_BASE_SCORE:     r_cfg.base_score     <= i_cfg_data[9:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // peer table
    prpt_table #(
        .DEPTH (PEER_SLOTS),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (AW'(i_in.peer_index)),
        .o_rd_data (w_rd_entry),
        .i_wr_en   (w_mem_wr),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data)
    );

    // entry update and result
    prpt_update u_update (
        .i_item     (r_item),
        .i_in_range (r_in_range),
        .i_entry    (w_rd_entry),
        .i_cfg      (r_cfg),
        .o_wr_en    (w_upd_wr),
        .o_entry    (w_upd_entry),
        .o_result   (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `PRPT_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n,
        r_state == prpt_pkg::ST_CLEAR, !o_in_ready)
    `PRPT_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n,
        w_accept, r_state == prpt_pkg::ST_BUSY)
    `PRPT_ASSERT_NEXT(a_done_fills_output, i_clk, i_rst_n,
        w_done, o_out_valid)
    `PRPT_ASSERT_NOW(a_score_floor, i_clk, i_rst_n,
        o_out_valid, o_out.score == 16'd0 || o_out.score >= prpt_pkg::SCORE_FLOOR)

endmodule

// ===== tb/peer_reorg_penalty_tracker_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_reorg_penalty_tracker_checker
// passive scoreboard for the peer reorg penalty tracker
// ----------------------------------------------------------------------------
// Watches the item, result and configuration channels at the rising edge.
// Keeps a private copy of the peer table and the registers, works out the
// verdict of every accepted item and queues it, then compares each accepted
// result beat against the oldest queued verdict, field by field.
// ----------------------------------------------------------------------------
module peer_reorg_penalty_tracker_checker #(
    parameter int PEER_SLOTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  prpt_pkg::t_in                    i_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  prpt_pkg::t_out                   i_out,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [prpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    // shadow registers
    logic [31:0] win_ticks;
    logic [15:0] deep_limit;
    logic [7:0]  attempt_limit;
    logic [9:0]  base_pts;

    // shadow peer table
    logic [31:0] peer_time  [PEER_SLOTS];
    logic [7:0]  peer_tries [PEER_SLOTS];
    logic [7:0]  peer_deep  [PEER_SLOTS];
    logic        peer_flag  [PEER_SLOTS];

    prpt_pkg::t_out pending_verdicts[$];
    int             mismatches;
    int             compared;
    int             pend_count;

    assign o_fail_count = mismatches;
    assign o_pending    = pend_count;
    assign o_checked    = compared;

    function automatic logic [7:0] bump_count(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    // back to the after-reset picture
    task automatic clear_shadow();
        win_ticks     = prpt_pkg::WINDOW_TICKS_RST;
        deep_limit    = prpt_pkg::DEEP_THRESHOLD_RST;
        attempt_limit = prpt_pkg::MAX_ATTEMPTS_RST;
        base_pts      = prpt_pkg::BASE_SCORE_RST;
        for (int k = 0; k < PEER_SLOTS; k++) begin
            peer_time[k]  = '0;
            peer_tries[k] = '0;
            peer_deep[k]  = '0;
            peer_flag[k]  = 1'b0;
        end
    endtask

    // register write, unknown indexes dropped
    task automatic write_shadow_reg(input logic [prpt_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
        case (idx)
            prpt_pkg::CFG_WINDOW_TICKS:   win_ticks     = data;
            prpt_pkg::CFG_DEEP_THRESHOLD: deep_limit    = data[15:0];
            prpt_pkg::CFG_MAX_ATTEMPTS:   attempt_limit = data[7:0];
            prpt_pkg::CFG_BASE_SCORE:     base_pts      = data[9:0];
            default: ;
        endcase
    endtask

    // one peer event: update the shadow table and form the verdict
    task automatic score_peer_event(input prpt_pkg::t_in beat, output prpt_pkg::t_out verdict);
        int unsigned slot;
        int unsigned pts;
        slot    = 32'(beat.peer_index);
        verdict = '0;
        if (slot < PEER_SLOTS) begin
            case (beat.mode)
                prpt_pkg::MODE_TRACK: begin
                    // idle past the window restarts the counts; time going back does not
                    if (beat.now >= peer_time[slot] &&
                        (beat.now - peer_time[slot]) > win_ticks) begin
                        peer_tries[slot] = '0;
                        peer_deep[slot]  = '0;
                    end
                    peer_time[slot]  = beat.now;
                    peer_tries[slot] = bump_count(peer_tries[slot]);
                    if (beat.depth > deep_limit)
                        peer_deep[slot] = bump_count(peer_deep[slot]);
                end
                prpt_pkg::MODE_QUERY: begin
                    verdict.should_punish = (peer_tries[slot] > attempt_limit) ||
                                            (peer_deep[slot] > 8'd1) || peer_flag[slot];
                end
                prpt_pkg::MODE_PUNISH: begin
                    peer_flag[slot] = 1'b1;
                    pts = 32'(base_pts);
                    pts = pts * (32'd1 + 32'(peer_deep[slot]));
                    if (peer_tries[slot] > attempt_limit)
                        pts = pts * 32'd2;
                    if (pts > 32'(prpt_pkg::SCORE_MAX))
                        pts = 32'(prpt_pkg::SCORE_MAX);
                    if (pts < 32'(prpt_pkg::SCORE_FLOOR))
                        pts = 32'(prpt_pkg::SCORE_FLOOR);
                    verdict.score = pts[15:0];
                end
                prpt_pkg::MODE_RESET: begin
                    peer_time[slot]  = '0;
                    peer_tries[slot] = '0;
                    peer_deep[slot]  = '0;
                    peer_flag[slot]  = 1'b0;
                end
                default: ;
            endcase
        end
    endtask

    initial begin
        mismatches = 0;
        compared   = 0;
        pend_count = 0;
        clear_shadow();
    end

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        prpt_pkg::t_out want;
        prpt_pkg::t_out fresh;
        if (!i_rst_n) begin
            clear_shadow();
            pending_verdicts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_shadow_reg(i_cfg_index, i_cfg_data);

            // result beat first: it belongs to an item taken earlier
            if (i_out_valid && i_out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    $error("result beat with nothing pending: should_punish %0d score %0d",
                           i_out.should_punish, i_out.score);
                end else begin
                    want = pending_verdicts.pop_front();
                    compared++;
                    if (i_out.should_punish !== want.should_punish) begin
                        mismatches++;
                        $error("should_punish mismatch: expected %0d, actual %0d",
                               want.should_punish, i_out.should_punish);
                    end
                    if (i_out.score !== want.score) begin
                        mismatches++;
                        $error("score mismatch: expected %0d, actual %0d",
                               want.score, i_out.score);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                score_peer_event(i_in, fresh);
                pending_verdicts.push_back(fresh);
            end
        end
        pend_count = pending_verdicts.size();
    end

endmodule

// ===== tb/tb_peer_reorg_penalty_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_reorg_penalty_tracker
// stimulus and verdict for the peer reorg penalty tracker
// ----------------------------------------------------------------------------
// Drives item beats and register writes at the falling edge, with random
// gaps on the item side and random back-pressure on the result side. A
// directed opener hits the field extremes and the corner cases, then random
// phases run under default, minimum, maximum and random register settings,
// including one long result stall that backs the block up. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_peer_reorg_penalty_tracker;

    localparam int PEER_SLOTS     = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRESSURE_HOLD  = 300;

    // register indexes the block does not decode
    localparam logic [prpt_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd4;
    localparam logic [prpt_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hff;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           in_valid;
    logic                           in_ready;
    prpt_pkg::t_in                  in_beat;
    logic                           out_valid;
    logic                           out_ready;
    prpt_pkg::t_out                 out_beat;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [prpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    int fail_count;
    int pending;
    int checked;

    // stimulus bookkeeping
    logic [31:0] clock_now;
    bit          calm;
    int          hold_req;
    int          directed_sent;
    int          random_sent;
    int          cfg_writes;
    int          quiet_cycles;

    peer_reorg_penalty_tracker #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    peer_reorg_penalty_tracker_checker #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // gap lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic prpt_pkg::t_in peer_beat(input prpt_pkg::t_mode m, input logic [5:0] p,
                                                input logic [15:0] d, input logic [31:0] n);
        prpt_pkg::t_in b;
        b.mode       = m;
        b.peer_index = p;
        b.depth      = d;
        b.now        = n;
        return b;
    endfunction

    // random peer event, biased toward a few hot peers and rising time
    function automatic prpt_pkg::t_in random_event(input int hot, input int step,
                                                   input int track_pct,
                                                   input bit allow_reset, input int wide_pct);
        prpt_pkg::t_in b;
        int            r;
        r = $urandom_range(0, 99);
        if (r < track_pct)
            b.mode = prpt_pkg::MODE_TRACK;
        else begin
            r = $urandom_range(0, 99);
            if (r < 45)
                b.mode = prpt_pkg::MODE_QUERY;
            else if (r < 85 || !allow_reset)
                b.mode = prpt_pkg::MODE_PUNISH;
            else
                b.mode = prpt_pkg::MODE_RESET;
        end

        if ($urandom_range(0, 99) < wide_pct)
            b.peer_index = 6'($urandom_range(0, 63));
        else
            b.peer_index = 6'($urandom_range(0, hot - 1));

        r = $urandom_range(0, 99);
        if (r < 45)
            b.depth = 16'($urandom_range(0, 12));
        else if (r < 90)
            b.depth = 16'($urandom_range(0, 65535));
        else
            b.depth = (r < 95) ? 16'h0000 : 16'hffff;

        // time: small steps, wild jumps, slips backwards, idle gaps
        r = $urandom_range(0, 99);
        if (r < 85) begin
            clock_now = clock_now + $urandom_range(0, step);
            b.now = clock_now;
        end else if (r < 90) begin
            clock_now = $urandom;
            b.now = clock_now;
        end else if (r < 95) begin
            b.now = clock_now - $urandom_range(1, 50);
        end else begin
            clock_now = clock_now + $urandom_range(1000, 20000);
            b.now = clock_now;
        end
        return b;
    endfunction

    // offer one item beat after a gap, return once it is taken
    task automatic send_item(input prpt_pkg::t_in beat, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_directed(input prpt_pkg::t_in beat);
        send_item(beat, pick_gap());
        directed_sent++;
    endtask

    task automatic cfg_write(input logic [prpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // stop offering and let every outstanding result drain
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int hot, input int step,
                              input int track_pct, input bit allow_reset,
                              input int wide_pct, input int hold, input int calm_items);
        int burst;
        burst = 0;
        if (hold > 0) begin
            hold_req = hold;
            burst    = 60;
        end
        for (int i = 0; i < count; i++) begin
            calm = (i < calm_items);
            send_item(random_event(hot, step, track_pct, allow_reset, wide_pct),
                      (i < burst) ? 0 : pick_gap());
            random_sent++;
        end
        calm = 1'b0;
    endtask

    // result side: random stalls, plus a long hold when asked for
    initial begin
        int stall_left;
        int r;
        logic ready_next;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                ready_next = 1'b0;
                stall_left--;
            end else if (calm) begin
                ready_next = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    ready_next = 1'b1;
                else begin
                    ready_next = 1'b0;
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) - 1
                                                              : $urandom_range(1, 3) - 1;
                end
            end
            out_ready <= ready_next;
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        in_valid      = 1'b0;
        in_beat       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        clock_now     = '0;
        calm          = 1'b0;
        hold_req      = 0;
        directed_sent = 0;
        random_sent   = 0;
        cfg_writes    = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opener under reset register values
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd0,  16'h0000, 32'h0000_0000));
        send_directed(peer_beat(prpt_pkg::MODE_PUNISH, 6'd5,  16'h0000, 32'h0000_0000));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd5,  16'hffff, 32'hffff_ffff));
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd0,  16'h0000, 32'd0));
        // depth equal to the threshold is not deep, one above is
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd0,  16'd6,    32'd100));
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd0,  16'd7,    32'd200));
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd0,  16'hffff, 32'd300));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd0,  16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_PUNISH, 6'd0,  16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd63, 16'hffff, 32'hffff_ffff));
        // time going backwards keeps the counts
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd63, 16'h0000, 32'd10));
        // idle exactly the window, then one past it
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd63, 16'h0000, 32'd3610));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd63, 16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_TRACK,  6'd63, 16'h0000, 32'd7211));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd63, 16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_PUNISH, 6'd63, 16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_RESET,  6'd0,  16'hffff, 32'hffff_ffff));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd0,  16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_PUNISH, 6'd0,  16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_RESET,  6'd63, 16'h0000, 32'd0));
        send_directed(peer_beat(prpt_pkg::MODE_QUERY,  6'd63, 16'h0000, 32'd0));

        // defaults, with a long result stall at the start
        clock_now = 32'd10_000;
        run_random(200, 4, 60, 55, 1'b1, 20, PRESSURE_HOLD, 0);
        drain();

        // every register at its low end, plus writes to undecoded indexes
        cfg_write(prpt_pkg::CFG_WINDOW_TICKS,   32'h0000_0000);
        cfg_write(prpt_pkg::CFG_DEEP_THRESHOLD, {16'($urandom_range(0, 65535)), 16'h0000});
        cfg_write(prpt_pkg::CFG_MAX_ATTEMPTS,   {24'($urandom), 8'h00});
        cfg_write(prpt_pkg::CFG_BASE_SCORE,     {22'($urandom), 10'h000});
        cfg_write(CFG_IDX_UNUSED,               $urandom);
        cfg_write(CFG_IDX_TOP,                  $urandom);
        run_random(150, 3, 2, 55, 1'b1, 20, 0, 0);
        drain();

        // every register but the deep threshold at its high end, the threshold at zero: counts run into saturation
        cfg_write(prpt_pkg::CFG_WINDOW_TICKS,   32'hffff_ffff);
        cfg_write(prpt_pkg::CFG_DEEP_THRESHOLD, {16'($urandom_range(0, 65535)), 16'h0000});
        cfg_write(prpt_pkg::CFG_MAX_ATTEMPTS,   {24'($urandom), 8'hff});
        cfg_write(prpt_pkg::CFG_BASE_SCORE,     {22'($urandom), 10'h3ff});
        run_random(320, 1, 40, 90, 1'b0, 3, 0, 0);
        drain();

        // random mid-range settings, opening with a stretch of no idling
        cfg_write(prpt_pkg::CFG_WINDOW_TICKS,   $urandom_range(50, 8000));
        cfg_write(prpt_pkg::CFG_DEEP_THRESHOLD,
                  ($urandom & 32'hffff_0000) | $urandom_range(0, 20));
        cfg_write(prpt_pkg::CFG_MAX_ATTEMPTS,
                  ($urandom & 32'hffff_ff00) | $urandom_range(0, 20));
        cfg_write(prpt_pkg::CFG_BASE_SCORE,     $urandom);
        run_random(180, 3, 80, 65, 1'b1, 15, 0, 60);
        drain();

        $display("covered %0d directed and %0d random items across %0d register writes",
                 directed_sent, random_sent, cfg_writes);
        $display("%0d result beats compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
